/* design/rde_pkg.sv */
// ----------------------------------------------------------------------------
// rde_pkg: shared types and constants for the ring deque engine
// Beat payloads, command and result codes, controller/datapath bundles and
// the ring index helper.
// ----------------------------------------------------------------------------
package rde_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

	// command codes
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_TRAVERSE   = 3'd4;

	// result kinds
	localparam logic [2:0] KIND_PUSH_DONE = 3'd0;
	localparam logic [2:0] KIND_POPPED    = 3'd1;
	localparam logic [2:0] KIND_TRAV      = 3'd2;
	localparam logic [2:0] KIND_EMPTY     = 3'd3;
	localparam logic [2:0] KIND_FULL      = 3'd4;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] value_res;
		logic               last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       ins_front;
		logic       ins_back;
		logic       rem_front;
		logic       rem_back;
		logic       trav_clr;
		logic       trav_rd;
		logic       out_load;
		logic [2:0] out_kind;
		logic       out_from_mem;
		logic       out_last_trav;
	} rde_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic out_free;
		logic trav_last;
	} rde_stat_t;

	// (base + off) mod DEPTH, base < DEPTH and off <= DEPTH
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_DEPTH) begin
			sum = sum - SUM_DEPTH;
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

/* design/rde_ctrl.sv */
// ----------------------------------------------------------------------------
// rde_ctrl: command sequencer of the ring deque engine
// Decodes request beats and steps pops and traversals through the datapath.
// ----------------------------------------------------------------------------
module rde_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [2:0]          req_command,
	output logic                req_stall,
	input  rde_pkg::rde_stat_t  stat,
	output rde_pkg::rde_cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_POP      = 2'd1;
	localparam logic [1:0] ST_TRAV_RD  = 2'd2;
	localparam logic [1:0] ST_TRAV_OUT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       accept;

	assign req_stall = !((state_q == ST_IDLE) && stat.out_free);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_command)
						rde_pkg::CMD_PUSH_FRONT, rde_pkg::CMD_PUSH_BACK: begin
							cmd.out_load = 1'b1;
							if (stat.full) begin
								cmd.out_kind = rde_pkg::KIND_FULL;
							end else begin
								cmd.out_kind  = rde_pkg::KIND_PUSH_DONE;
								cmd.ins_front = (req_command == rde_pkg::CMD_PUSH_FRONT);
								cmd.ins_back  = (req_command == rde_pkg::CMD_PUSH_BACK);
							end
						end
						rde_pkg::CMD_POP_FRONT, rde_pkg::CMD_POP_BACK: begin
							if (stat.empty) begin
								cmd.out_load = 1'b1;
								cmd.out_kind = rde_pkg::KIND_EMPTY;
							end else begin
								cmd.rem_front = (req_command == rde_pkg::CMD_POP_FRONT);
								cmd.rem_back  = (req_command == rde_pkg::CMD_POP_BACK);
								state_nx      = ST_POP;
							end
						end
						rde_pkg::CMD_TRAVERSE: begin
							if (stat.empty) begin
								cmd.out_load = 1'b1;
								cmd.out_kind = rde_pkg::KIND_EMPTY;
							end else begin
								cmd.trav_clr = 1'b1;
								state_nx     = ST_TRAV_RD;
							end
						end
						default: begin
							// unused codes: dropped silently
						end
					endcase
				end
			end
			ST_POP: begin
				if (stat.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_kind     = rde_pkg::KIND_POPPED;
					cmd.out_from_mem = 1'b1;
					state_nx         = ST_IDLE;
				end
			end
			ST_TRAV_RD: begin
				cmd.trav_rd = 1'b1;
				state_nx    = ST_TRAV_OUT;
			end
			ST_TRAV_OUT: begin
				if (stat.out_free) begin
					cmd.out_load      = 1'b1;
					cmd.out_kind      = rde_pkg::KIND_TRAV;
					cmd.out_from_mem  = 1'b1;
					cmd.out_last_trav = 1'b1;
					state_nx          = stat.trav_last ? ST_IDLE : ST_TRAV_RD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

/* design/rde_dp.sv */
// ----------------------------------------------------------------------------
// rde_dp: storage and pointers of the ring deque engine
// Entry memory, front pointer, occupancy, traversal counter, output register.
// ----------------------------------------------------------------------------
module rde_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic signed [31:0]    word,
	input  rde_pkg::rde_cmd_t     cmd,
	output rde_pkg::rde_stat_t    stat,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rde_pkg::rsp_t         rsp
);

	logic [31:0]                  mem [rde_pkg::DEPTH];
	logic [31:0]                  rd_q;
	logic [rde_pkg::IDX_W-1:0]    front_q;
	logic [rde_pkg::CNT_W-1:0]    occ_q;
	logic [rde_pkg::IDX_W-1:0]    trav_q;
	logic                         trav_last_q;
	logic                         out_valid_q;
	rde_pkg::rsp_t                out_q;

	logic [rde_pkg::IDX_W-1:0]    front_dec;
	logic [rde_pkg::IDX_W-1:0]    front_inc;
	logic [rde_pkg::IDX_W-1:0]    pos_back;
	logic [rde_pkg::IDX_W-1:0]    pos_back_last;
	logic [rde_pkg::IDX_W-1:0]    pos_trav;
	logic [rde_pkg::IDX_W-1:0]    wr_addr;
	logic [rde_pkg::IDX_W-1:0]    rd_addr;
	logic                         wr_en;
	logic                         rd_en;
	logic                         out_free;

	assign front_dec     = (front_q == '0) ? rde_pkg::IDX_LAST : front_q - 1'b1;
	assign front_inc     = (front_q == rde_pkg::IDX_LAST) ? '0 : front_q + 1'b1;
	assign pos_back      = rde_pkg::ring_add(front_q, occ_q);
	assign pos_back_last = rde_pkg::ring_add(front_q, occ_q - 1'b1);
	assign pos_trav      = rde_pkg::ring_add(front_q, rde_pkg::CNT_W'(trav_q));

	assign wr_en   = cmd.ins_front || cmd.ins_back;
	assign wr_addr = cmd.ins_front ? front_dec : pos_back;
	assign rd_en   = cmd.rem_front || cmd.rem_back || cmd.trav_rd;
	assign rd_addr = cmd.rem_front ? front_q : (cmd.rem_back ? pos_back_last : pos_trav);

	assign out_free = !out_valid_q || !rsp_stall;

	assign stat.empty     = (occ_q == '0);
	assign stat.full      = (occ_q == rde_pkg::CNT_FULL);
	assign stat.out_free  = out_free;
	assign stat.trav_last = trav_last_q;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// single-port entry store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= word;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_front) begin
				front_q <= front_dec;
			end else if (cmd.rem_front) begin
				front_q <= front_inc;
			end
			if (wr_en) begin
				occ_q <= occ_q + 1'b1;
			end else if (cmd.rem_front || cmd.rem_back) begin
				occ_q <= occ_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.trav_clr) begin
			trav_q <= '0;
		end else if (cmd.trav_rd) begin
			trav_q      <= trav_q + 1'b1;
			trav_last_q <= ((rde_pkg::CNT_W'(trav_q) + 1'b1) == occ_q);
		end
		if (cmd.out_load) begin
			out_q.kind      <= cmd.out_kind;
			out_q.value_res <= cmd.out_from_mem ? rd_q : '0;
			out_q.last      <= cmd.out_last_trav ? trav_last_q : 1'b1;
		end
	end

endmodule

/* design/ring_deque_engine_unit.sv */
// ----------------------------------------------------------------------------
// ring_deque_engine_unit: double-ended queue of signed words in a ring
// Push and pop at either end, or walk the queue front to back.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat payload                       | notes
//  --------+-----+------------------------------------+---------------------------
//  req     | in  | command, value                     | one command per beat
//  rsp     | out | kind, value_res, last              | last marks a command's end
//
// Steps: push, full and empty results load the output as the beat is taken; a
// pop reads memory, then loads the output; a traversal clears its counter, then
// reads and loads each word, as the single-port memory has registered read data.
// Reset: arst_n clears front pointer, occupancy, sequencer and output valid;
// the entry memory is not cleared and is only ever read where written.
// Stalls: a new beat is taken while the sequencer is idle and the output
// register is empty or being drained; rsp_stall freezes the pending result.
// Command codes 5 to 7 are taken and produce no result.
//
module ring_deque_engine_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rde_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rde_pkg::rsp_t  rsp
);

	rde_pkg::rde_cmd_t  cmd;
	rde_pkg::rde_stat_t stat;

	// sequencer: decodes beats, walks pops and traversals
	rde_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.req_stall   (req_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	// storage, pointers and the result register
	rde_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.word      (req.value),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

/* design/rde_chk.sv */
// ----------------------------------------------------------------------------
// rde_chk: port-level checks for the ring deque engine
// Watches handshake and result coding on the top level ports.
// ----------------------------------------------------------------------------
module rde_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input rde_pkg::rsp_t  rsp
);

	// stalled result beat stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp beat changed under stall");

	// a blocked output back-pressures the request side
	a_req_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while result is blocked");

	// only popped and traversal words carry data
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == rde_pkg::KIND_PUSH_DONE ||
		rsp.kind == rde_pkg::KIND_EMPTY || rsp.kind == rde_pkg::KIND_FULL)
		|-> rsp.value_res == '0)
		else $error("nonzero value on a status result");

	// every non-traversal result ends its command
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != rde_pkg::KIND_TRAV |-> rsp.last)
		else $error("single result without last");

	// no request beat is taken while a traversal is still streaming
	a_trav_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && rsp.kind == rde_pkg::KIND_TRAV && !rsp.last
		|-> req_stall)
		else $error("request taken mid traversal");

endmodule

bind ring_deque_engine_unit rde_chk u_rde_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

/* test/ring_deque_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// ring_deque_engine_unit_tb: self-checking bench for the ring deque engine
// Command beats are sent from a queue with random gaps while the result
// side stalls at random. Each accepted command is run through a deque model
// kept here, and every accepted result beat is checked field by field.
// ----------------------------------------------------------------------------
module ring_deque_engine_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// spare command codes, taken by the block and answered with nothing
	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

	localparam int RANDOM_BEATS   = 204;
	localparam int PRESSURE_AT    = 120;  // command beats taken before the long hold-off
	localparam int HOLD_CYCLES    = 90;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	rde_pkg::req_t  req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	rde_pkg::rsp_t  rsp;

	ring_deque_engine_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// Deque model: own copy of the ring, front index and word count
	// ------------------------------------------------------------------------
	logic signed [31:0] deque_words [rde_pkg::DEPTH];
	int                 head_idx = 0;
	int                 word_count = 0;
	rde_pkg::rsp_t      expected_rsp [$];
	rde_pkg::req_t      pending_cmds [$];
	int                 error_count = 0;

	task automatic expect_beat(input logic [2:0] kind, input logic signed [31:0] word,
		input logic last);
		rde_pkg::rsp_t beat;
		beat.kind      = kind;
		beat.value_res = word;
		beat.last      = last;
		expected_rsp.insert(expected_rsp.size(), beat);
	endtask

	task automatic apply_command(input rde_pkg::req_t item);
		int slot;
		case (item.command)
			rde_pkg::CMD_PUSH_FRONT, rde_pkg::CMD_PUSH_BACK: begin
				if (word_count == rde_pkg::DEPTH) begin
					// full: word dropped, nothing moves
					expect_beat(rde_pkg::KIND_FULL, '0, 1'b1);
				end else begin
					if (item.command == rde_pkg::CMD_PUSH_FRONT) begin
						head_idx = (head_idx + rde_pkg::DEPTH - 1) % rde_pkg::DEPTH;
						slot = head_idx;
					end else begin
						slot = (head_idx + word_count) % rde_pkg::DEPTH;
					end
					deque_words[slot] = item.value;
					word_count++;
					expect_beat(rde_pkg::KIND_PUSH_DONE, '0, 1'b1);
				end
			end
			rde_pkg::CMD_POP_FRONT, rde_pkg::CMD_POP_BACK: begin
				if (word_count == 0) begin
					expect_beat(rde_pkg::KIND_EMPTY, '0, 1'b1);
				end else begin
					if (item.command == rde_pkg::CMD_POP_FRONT) begin
						slot = head_idx;
						head_idx = (head_idx + 1) % rde_pkg::DEPTH;
					end else begin
						slot = (head_idx + word_count - 1) % rde_pkg::DEPTH;
					end
					word_count--;
					expect_beat(rde_pkg::KIND_POPPED, deque_words[slot], 1'b1);
				end
			end
			rde_pkg::CMD_TRAVERSE: begin
				if (word_count == 0) begin
					expect_beat(rde_pkg::KIND_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < word_count; i++) begin
						expect_beat(rde_pkg::KIND_TRAV,
							deque_words[(head_idx + i) % rde_pkg::DEPTH],
							i == word_count - 1);
					end
				end
			end
			default: begin
				// spare codes: no result, no state change
			end
		endcase
	endtask

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// ------------------------------------------------------------------------
	// Gap lengths: mostly none or short, now and then a long one
	// ------------------------------------------------------------------------
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	// ------------------------------------------------------------------------
	// Command driver: holds a stalled beat, else idles or sends the next one
	// ------------------------------------------------------------------------
	int gap_left;
	int calm_left;
	int sent_beats;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			req        <= '0;
			sent_beats <= 0;
			gap_left = 0;
			calm_left = 0;
		end else begin
			if (req_valid && !req_stall) begin
				sent_beats <= sent_beats + 1;
				// stretches with back-to-back beats now and then
				if (calm_left > 0) begin
					calm_left--;
					gap_left = 0;
				end else begin
					gap_left = pick_pause();
					if ($urandom_range(0, 29) == 0) begin
						calm_left = $urandom_range(15, 40);
					end
				end
			end
			if (req_valid && req_stall) begin
				// stalled beat stays as it is
			end else if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				req       <= pending_cmds[0];
				req_valid <= 1'b1;
				pending_cmds.delete(0);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result stall: alternating free and stalled runs, plus one long hold-off
	// once enough commands went in, so the block backs up into req_stall
	// ------------------------------------------------------------------------
	int  stall_left;
	int  free_left;
	int  hold_left;
	bit  pressure_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
			free_left = 0;
			hold_left = 0;
			pressure_done = 1'b0;
		end else begin
			if (!pressure_done && sent_beats >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				rsp_stall <= 1'b0;
			end else begin
				free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
					: $urandom_range(0, 6);
				stall_left = pick_pause();
				rsp_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check the result beat first, then model the command beat taken
	// on the same edge (its results can only come later)
	// ------------------------------------------------------------------------
	rde_pkg::rsp_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch($sformatf("unexpected beat kind=%0d value=%0d last=%0b",
						rsp.kind, rsp.value_res, rsp.last));
				end else begin
					want = expected_rsp[0];
					expected_rsp.delete(0);
					if (rsp.kind !== want.kind)
						report_mismatch($sformatf("kind %0d, want %0d", rsp.kind, want.kind));
					if (rsp.value_res !== want.value_res)
						report_mismatch($sformatf("value_res %0d, want %0d",
							rsp.value_res, want.value_res));
					if (rsp.last !== want.last)
						report_mismatch($sformatf("last %0b, want %0b", rsp.last, want.last));
				end
			end
			if (req_valid && !req_stall) begin
				apply_command(req);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long with no beat taken on either side ends the run
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic add_cmd(input logic [2:0] command, input logic signed [31:0] word);
		rde_pkg::req_t item;
		item.command = command;
		item.value   = word;
		pending_cmds.insert(pending_cmds.size(), item);
	endtask

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 15))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Random part: runs of fill-heavy, drain-heavy or balanced traffic so
	// the deque swings between empty and full and both ends get worked.
	task automatic add_random_cmds(input int count);
		int         push_share;
		int         r;
		logic [2:0] command;
		push_share = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 24 == 0) begin
				case ($urandom_range(0, 2))
					0: push_share = 78;
					1: push_share = 22;
					default: push_share = 50;
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 3) begin
				command = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
			end else if (r < 14) begin
				command = rde_pkg::CMD_TRAVERSE;
			end else if ($urandom_range(0, 99) < push_share) begin
				command = $urandom_range(0, 1) ? rde_pkg::CMD_PUSH_BACK
					: rde_pkg::CMD_PUSH_FRONT;
			end else begin
				command = $urandom_range(0, 1) ? rde_pkg::CMD_POP_BACK
					: rde_pkg::CMD_POP_FRONT;
			end
			add_cmd(command, pick_word());
		end
	endtask

	initial begin
		// empty deque: pop and walk report empty, spare code ignored
		add_cmd(rde_pkg::CMD_POP_FRONT, 32'sh1234_5678);
		add_cmd(rde_pkg::CMD_TRAVERSE, '0);
		add_cmd(CMD_SPARE_LO, -32'sd1);
		// fill to the brim from both ends, extremes among the words
		add_cmd(rde_pkg::CMD_PUSH_FRONT, 32'sh7fff_ffff);
		add_cmd(rde_pkg::CMD_PUSH_BACK, 32'sh8000_0000);
		add_cmd(rde_pkg::CMD_PUSH_FRONT, '0);
		add_cmd(rde_pkg::CMD_PUSH_BACK, -32'sd1);
		add_cmd(rde_pkg::CMD_PUSH_FRONT, 32'shaaaa_aaaa);
		add_cmd(rde_pkg::CMD_PUSH_BACK, 32'sh5555_5555);
		for (int i = 0; i < rde_pkg::DEPTH - 6; i++) begin
			add_cmd((i % 2) ? rde_pkg::CMD_PUSH_BACK : rde_pkg::CMD_PUSH_FRONT, $urandom);
		end
		// full: both pushes dropped, a 16-word walk, then both pops
		add_cmd(rde_pkg::CMD_PUSH_FRONT, 32'sh0bad_0bad);
		add_cmd(rde_pkg::CMD_PUSH_BACK, -32'sd2);
		add_cmd(rde_pkg::CMD_TRAVERSE, 32'sh7fff_ffff);
		add_cmd(rde_pkg::CMD_POP_FRONT, '0);
		add_cmd(rde_pkg::CMD_POP_BACK, '0);
		add_cmd(CMD_SPARE_MID, 32'sh8000_0000);
		add_cmd(CMD_SPARE_HI, '0);
		add_random_cmds(RANDOM_BEATS);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// all sent, all answered, then a quiet tail to catch stray beats
		@(negedge clk);
		while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/rde_pkg.sv
design/rde_ctrl.sv
design/rde_dp.sv
design/ring_deque_engine_unit.sv
design/rde_chk.sv
test/ring_deque_engine_unit_tb.sv
